### src/sprs_pkg.sv
// Shared constants, codes and types for the sparse row store.
package sprs_pkg;

    localparam int ROWS   = 64;
    localparam int COLS   = 64;
    localparam int SLOTS  = 16;
    localparam int VW     = 32;
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int SW     = $clog2(SLOTS);
    localparam int FW     = $clog2(SLOTS + 1);
    localparam int AW     = RW + SW;
    localparam int CFGW   = 7;
    localparam int CFG_IW = 1;

    localparam logic [CFG_IW-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IW-1:0] REG_COLS = 1'd1;

    localparam logic [2:0] MODE_SET   = 3'd0;
    localparam logic [2:0] MODE_GET   = 3'd1;
    localparam logic [2:0] MODE_ALLOC = 3'd2;
    localparam logic [2:0] MODE_VEC   = 3'd3;
    localparam logic [2:0] MODE_ACC   = 3'd4;
    localparam logic [2:0] MODE_MUL   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        DOP_NONE,
        DOP_LATCH,
        DOP_DECODE,
        DOP_SEEK_RD,
        DOP_SEEK_CMP,
        DOP_MISS,
        DOP_SHIFT_RD,
        DOP_SHIFT_WR,
        DOP_INSERT,
        DOP_OUT,
        DOP_MROW,
        DOP_MSTART,
        DOP_MRD,
        DOP_MVEC,
        DOP_MMUL,
        DOP_MACC,
        DOP_MDONE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       oor;
        logic       seek_end;
        logic       col_lt;
        logic       col_eq;
        logic       full;
        logic       shift_done;
        logic       m_end;
        logic       last;
        logic       out_free;
    } t_stat;

    typedef struct packed {
        logic [CW-1:0] col;
        logic [VW-1:0] val;
    } t_entry;

endpackage

### src/sprs_in_if.sv
// Input item channel.
interface sprs_in_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   mode;
    logic [sprs_pkg::RW-1:0]      row;
    logic [sprs_pkg::CW-1:0]      col;
    logic signed [sprs_pkg::VW-1:0] value;

    modport source (output valid, mode, row, col, value, input ready);
    modport sink   (input valid, mode, row, col, value, output ready);
endinterface

### src/sprs_out_if.sv
// Result item channel.
interface sprs_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [sprs_pkg::VW-1:0] data;
    logic [sprs_pkg::RW-1:0]        row_index;
    logic [1:0]                     status;
    logic                           last;

    modport source (output valid, data, row_index, status, last, input ready);
    modport sink   (input valid, data, row_index, status, last, output ready);
endinterface

### src/sparse_row_store_spmv.sv
// Sparse row store with matrix-vector multiply: top level.
// One item at a time. Loads and range errors give a single result; ignored modes give no result.
// Set/get/allocate: seek through the row's slots, then on an insert shift the later entries up.
// Multiply: one result per configured row, each stored entry read, multiplied and accumulated.
// Next item taken once the final result is loaded into the output register.
// Synchronous reset; stores read as zero through valid bits, no clearing pass.
module sparse_row_store_spmv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sprs_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [sprs_pkg::CFGW-1:0]   i_cfg_data,
    sprs_in_if.sink                     i_in,
    sprs_out_if.source                  o_out
);

    sprs_pkg::t_cmd  cmd;
    sprs_pkg::t_stat stat;

    sprs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sprs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_in.mode),
        .i_row        (i_in.row),
        .i_col        (i_in.col),
        .i_value      (i_in.value),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_data   (o_out.data),
        .o_out_row    (o_out.row_index),
        .o_out_status (o_out.status),
        .o_out_last   (o_out.last)
    );

    // a new item only follows the final result of the previous one
    a_accept_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && o_out.valid) |-> o_out.last)
        else $error("item taken while a non-final result waits");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != sprs_pkg::ST_OK) |-> (o_out.data == '0))
        else $error("error result carries data");

    a_mid_result_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (o_out.status == sprs_pkg::ST_OK))
        else $error("non-final result with error status");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready held after transfer");

endmodule

### src/sprs_ctrl.sv
// Controller state machine: sequences seek, shift, insert and multiply steps.
module sprs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sprs_pkg::t_stat i_stat,
    output sprs_pkg::t_cmd  o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_DECODE   = 17'b00000000000000010,
        S_SEEK_RD  = 17'b00000000000000100,
        S_SEEK_CMP = 17'b00000000000001000,
        S_MISS     = 17'b00000000000010000,
        S_SHIFT_RD = 17'b00000000000100000,
        S_SHIFT_WR = 17'b00000000001000000,
        S_INSERT   = 17'b00000000010000000,
        S_RESP     = 17'b00000000100000000,
        S_MROW     = 17'b00000001000000000,
        S_MSTART   = 17'b00000010000000000,
        S_MRD      = 17'b00000100000000000,
        S_MVEC     = 17'b00001000000000000,
        S_MMUL     = 17'b00010000000000000,
        S_MACC     = 17'b00100000000000000,
        S_MDONE    = 17'b01000000000000000,
        S_MOUT     = 17'b10000000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = sprs_pkg::DOP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = sprs_pkg::DOP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.op = sprs_pkg::DOP_DECODE;
                if (i_stat.mode > sprs_pkg::MODE_MUL) n_state = S_IDLE;
                else if (i_stat.oor) n_state = S_RESP;
                else if (i_stat.mode == sprs_pkg::MODE_VEC
                      || i_stat.mode == sprs_pkg::MODE_ACC) n_state = S_RESP;
                else if (i_stat.mode == sprs_pkg::MODE_MUL) n_state = S_MROW;
                else n_state = S_SEEK_RD;
            end
            S_SEEK_RD: begin
                o_cmd.op = sprs_pkg::DOP_SEEK_RD;
                n_state  = i_stat.seek_end ? S_MISS : S_SEEK_CMP;
            end
            S_SEEK_CMP: begin
                o_cmd.op = sprs_pkg::DOP_SEEK_CMP;
                if (i_stat.col_lt) n_state = S_SEEK_RD;
                else if (i_stat.col_eq) n_state = S_RESP;
                else n_state = S_MISS;
            end
            S_MISS: begin
                o_cmd.op = sprs_pkg::DOP_MISS;
                if (i_stat.mode == sprs_pkg::MODE_GET || i_stat.full) n_state = S_RESP;
                else n_state = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                o_cmd.op = sprs_pkg::DOP_SHIFT_RD;
                n_state  = i_stat.shift_done ? S_INSERT : S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.op = sprs_pkg::DOP_SHIFT_WR;
                n_state  = S_SHIFT_RD;
            end
            S_INSERT: begin
                o_cmd.op = sprs_pkg::DOP_INSERT;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.op = sprs_pkg::DOP_OUT;
                    n_state  = S_IDLE;
                end
            end
            S_MROW: begin
                o_cmd.op = sprs_pkg::DOP_MROW;
                n_state  = S_MSTART;
            end
            S_MSTART: begin
                o_cmd.op = sprs_pkg::DOP_MSTART;
                n_state  = S_MRD;
            end
            S_MRD: begin
                o_cmd.op = sprs_pkg::DOP_MRD;
                n_state  = i_stat.m_end ? S_MDONE : S_MVEC;
            end
            S_MVEC: begin
                o_cmd.op = sprs_pkg::DOP_MVEC;
                n_state  = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.op = sprs_pkg::DOP_MMUL;
                n_state  = S_MACC;
            end
            S_MACC: begin
                o_cmd.op = sprs_pkg::DOP_MACC;
                n_state  = S_MRD;
            end
            S_MDONE: begin
                o_cmd.op = sprs_pkg::DOP_MDONE;
                n_state  = S_MOUT;
            end
            S_MOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = sprs_pkg::DOP_OUT;
                    n_state  = i_stat.last ? S_IDLE : S_MROW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/sprs_dp.sv
// Datapath: entry, fill, vector and accumulator stores, counters, multiplier, result register.
module sprs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sprs_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [sprs_pkg::CFGW-1:0]       i_cfg_data,
    input  logic [2:0]                      i_mode,
    input  logic [sprs_pkg::RW-1:0]         i_row,
    input  logic [sprs_pkg::CW-1:0]         i_col,
    input  logic [sprs_pkg::VW-1:0]         i_value,
    input  sprs_pkg::t_cmd                  i_cmd,
    output sprs_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sprs_pkg::VW-1:0]         o_out_data,
    output logic [sprs_pkg::RW-1:0]         o_out_row,
    output logic [1:0]                      o_out_status,
    output logic                            o_out_last
);

    localparam int RW   = sprs_pkg::RW;
    localparam int CW   = sprs_pkg::CW;
    localparam int SW   = sprs_pkg::SW;
    localparam int FW   = sprs_pkg::FW;
    localparam int VW   = sprs_pkg::VW;
    localparam int AW   = sprs_pkg::AW;
    localparam int CFGW = sprs_pkg::CFGW;

    // configuration
    logic [CFGW-1:0] r_rows_cfg, r_cols_cfg;
    logic [CFGW-1:0] nr, nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= CFGW'(sprs_pkg::ROWS);
            r_cols_cfg <= CFGW'(sprs_pkg::COLS);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sprs_pkg::REG_ROWS) r_rows_cfg <= i_cfg_data;
            if (i_cfg_idx == sprs_pkg::REG_COLS) r_cols_cfg <= i_cfg_data;
        end
    end

    // clamp to 1..max
    always_comb begin
        nr = r_rows_cfg;
        if (r_rows_cfg == '0) nr = CFGW'(1);
        else if (r_rows_cfg > CFGW'(sprs_pkg::ROWS)) nr = CFGW'(sprs_pkg::ROWS);
        nc = r_cols_cfg;
        if (r_cols_cfg == '0) nc = CFGW'(1);
        else if (r_cols_cfg > CFGW'(sprs_pkg::COLS)) nc = CFGW'(sprs_pkg::COLS);
    end

    // latched item and working registers
    logic [2:0]    r_mode;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [VW-1:0] r_value;
    logic [FW-1:0] r_p, r_i;
    logic [RW-1:0] r_r;
    logic [VW-1:0] r_acc, r_prod;
    logic          r_use;

    logic [VW-1:0] r_res_data;
    logic [RW-1:0] r_res_row;
    logic [1:0]    r_res_status;
    logic          r_res_last;

    // stores
    sprs_pkg::t_entry m_entry [sprs_pkg::ROWS*sprs_pkg::SLOTS];
    sprs_pkg::t_entry r_ent_rd;
    logic [FW-1:0]    m_fill [sprs_pkg::ROWS];
    logic [FW-1:0]    r_fill_rd;
    logic [VW-1:0]    m_vec [sprs_pkg::COLS];
    logic [VW-1:0]    r_vec_rd;
    logic [VW-1:0]    m_acc [sprs_pkg::ROWS];
    logic [VW-1:0]    r_acc_rd;

    logic [sprs_pkg::ROWS-1:0] r_fill_v, r_acc_v;
    logic [sprs_pkg::COLS-1:0] r_vec_v;
    logic r_fill_ok, r_vec_ok, r_acc_ok;

    logic [FW-1:0] f_fill;
    logic          oor;
    logic [FW-1:0] i_dec;

    assign f_fill = r_fill_ok ? r_fill_rd : '0;
    assign i_dec  = r_i - FW'(1);

    always_comb begin
        oor = 1'b0;
        if (r_mode == sprs_pkg::MODE_SET || r_mode == sprs_pkg::MODE_GET
            || r_mode == sprs_pkg::MODE_ALLOC)
            oor = ({1'b0, r_row} >= nr) || ({1'b0, r_col} >= nc);
        else if (r_mode == sprs_pkg::MODE_VEC) oor = {1'b0, r_col} >= nc;
        else if (r_mode == sprs_pkg::MODE_ACC) oor = {1'b0, r_col} >= nr;
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.oor        = oor;
        o_stat.seek_end   = r_p >= f_fill;
        o_stat.col_lt     = r_ent_rd.col < r_col;
        o_stat.col_eq     = r_ent_rd.col == r_col;
        o_stat.full       = f_fill >= FW'(sprs_pkg::SLOTS);
        o_stat.shift_done = r_i == r_p;
        o_stat.m_end      = r_i >= f_fill;
        o_stat.last       = r_res_last;
        o_stat.out_free   = !o_out_valid || i_out_ready;
    end

    // entry store port control
    logic             ent_we, ent_re;
    logic [AW-1:0]    ent_waddr, ent_raddr;
    sprs_pkg::t_entry ent_wdata;

    always_comb begin
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_waddr = {r_row, r_p[SW-1:0]};
        ent_raddr = {r_row, r_p[SW-1:0]};
        ent_wdata = r_ent_rd;
        unique case (i_cmd.op)
            sprs_pkg::DOP_SEEK_RD: ent_re = 1'b1;
            sprs_pkg::DOP_SEEK_CMP: begin
                if (r_ent_rd.col == r_col && r_mode == sprs_pkg::MODE_SET) begin
                    ent_we        = 1'b1;
                    ent_wdata.col = r_col;
                    ent_wdata.val = r_value;
                end
            end
            sprs_pkg::DOP_SHIFT_RD: begin
                ent_re    = 1'b1;
                ent_raddr = {r_row, i_dec[SW-1:0]};
            end
            sprs_pkg::DOP_SHIFT_WR: begin
                ent_we    = 1'b1;
                ent_waddr = {r_row, r_i[SW-1:0]};
            end
            sprs_pkg::DOP_INSERT: begin
                ent_we        = 1'b1;
                ent_wdata.col = r_col;
                ent_wdata.val = (r_mode == sprs_pkg::MODE_SET) ? r_value : '0;
            end
            sprs_pkg::DOP_MRD: begin
                ent_re    = 1'b1;
                ent_raddr = {r_r, r_i[SW-1:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) m_entry[ent_waddr] <= ent_wdata;
        if (ent_re) r_ent_rd <= m_entry[ent_raddr];
    end

    // fill store
    logic          fill_re;
    logic [RW-1:0] fill_raddr;
    assign fill_re    = i_cmd.op == sprs_pkg::DOP_DECODE || i_cmd.op == sprs_pkg::DOP_MROW;
    assign fill_raddr = (i_cmd.op == sprs_pkg::DOP_MROW) ? r_r : r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sprs_pkg::DOP_INSERT) m_fill[r_row] <= f_fill + FW'(1);
        if (fill_re) r_fill_rd <= m_fill[fill_raddr];
    end

    // vector store
    logic vec_we;
    assign vec_we = i_cmd.op == sprs_pkg::DOP_DECODE && r_mode == sprs_pkg::MODE_VEC && !oor;

    always_ff @(posedge i_clk) begin
        if (vec_we) m_vec[r_col] <= r_value;
        if (i_cmd.op == sprs_pkg::DOP_MVEC) r_vec_rd <= m_vec[r_ent_rd.col];
    end

    // accumulator store
    logic          acc_we;
    logic [RW-1:0] acc_waddr;
    logic [VW-1:0] acc_wdata;

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = r_col;
        acc_wdata = r_value;
        if (i_cmd.op == sprs_pkg::DOP_DECODE && r_mode == sprs_pkg::MODE_ACC && !oor)
            acc_we = 1'b1;
        else if (i_cmd.op == sprs_pkg::DOP_MDONE) begin
            acc_we    = 1'b1;
            acc_waddr = r_r;
            acc_wdata = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) m_acc[acc_waddr] <= acc_wdata;
        if (i_cmd.op == sprs_pkg::DOP_MROW) r_acc_rd <= m_acc[r_r];
    end

    // valid bits stand in for the zero reset of the small stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_v <= '0;
            r_vec_v  <= '0;
            r_acc_v  <= '0;
        end else begin
            if (i_cmd.op == sprs_pkg::DOP_INSERT) r_fill_v[r_row] <= 1'b1;
            if (vec_we) r_vec_v[r_col] <= 1'b1;
            if (acc_we) r_acc_v[acc_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_re) r_fill_ok <= r_fill_v[fill_raddr];
        if (i_cmd.op == sprs_pkg::DOP_MVEC) r_vec_ok <= r_vec_v[r_ent_rd.col];
        if (i_cmd.op == sprs_pkg::DOP_MROW) r_acc_ok <= r_acc_v[r_r];
    end

    // counters, arithmetic and result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            sprs_pkg::DOP_LATCH: begin
                r_mode  <= i_mode;
                r_row   <= i_row;
                r_col   <= i_col;
                r_value <= i_value;
            end
            sprs_pkg::DOP_DECODE: begin
                r_p          <= '0;
                r_r          <= '0;
                r_res_data   <= '0;
                r_res_row    <= '0;
                r_res_last   <= 1'b1;
                r_res_status <= oor ? sprs_pkg::ST_RANGE : sprs_pkg::ST_OK;
            end
            sprs_pkg::DOP_SEEK_CMP: begin
                if (r_ent_rd.col < r_col) r_p <= r_p + FW'(1);
                r_res_data <= (r_mode == sprs_pkg::MODE_SET) ? '0 : r_ent_rd.val;
            end
            sprs_pkg::DOP_MISS: begin
                r_i          <= f_fill;
                r_res_data   <= '0;
                r_res_status <= (r_mode != sprs_pkg::MODE_GET && f_fill >= FW'(sprs_pkg::SLOTS))
                                ? sprs_pkg::ST_FULL : sprs_pkg::ST_OK;
            end
            sprs_pkg::DOP_SHIFT_WR: r_i <= i_dec;
            sprs_pkg::DOP_MROW:     r_i <= '0;
            sprs_pkg::DOP_MSTART:   r_acc <= r_acc_ok ? r_acc_rd : '0;
            sprs_pkg::DOP_MVEC:     r_use <= {1'b0, r_ent_rd.col} < nc;
            sprs_pkg::DOP_MMUL:     r_prod <= (r_use && r_vec_ok) ? r_ent_rd.val * r_vec_rd : '0;
            sprs_pkg::DOP_MACC: begin
                r_acc <= r_acc + r_prod;
                r_i   <= r_i + FW'(1);
            end
            sprs_pkg::DOP_MDONE: begin
                r_res_data   <= r_acc;
                r_res_row    <= r_r;
                r_res_status <= sprs_pkg::ST_OK;
                r_res_last   <= ({1'b0, r_r} + CFGW'(1)) == nr;
            end
            sprs_pkg::DOP_OUT: r_r <= r_r + RW'(1);
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == sprs_pkg::DOP_OUT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sprs_pkg::DOP_OUT) begin
            o_out_data   <= r_res_data;
            o_out_row    <= r_res_row;
            o_out_status <= r_res_status;
            o_out_last   <= r_res_last;
        end
    end

endmodule
